>>> hdl/short_descriptor_table_walk_assert.svh
// Assertion macros for the short-descriptor table walker.
// Used by the walk engine; no dependencies. Clock clk, reset rst_n.
`ifndef SHORT_DESCRIPTOR_TABLE_WALK_ASSERT_SVH
`define SHORT_DESCRIPTOR_TABLE_WALK_ASSERT_SVH

`ifndef ASSERT_OFF
`define SDTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SDTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDTW_ASSERT(lbl, prop, msg)
`define SDTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/sdtw_pkg.sv
// Shared types and codes for the short-descriptor table walker.
// No dependencies; imported by every module of the block.
package sdtw_pkg;

  localparam int unsigned VA_W    = 32;
  localparam int unsigned DESC_W  = 32;
  localparam int unsigned PA_W    = 40;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned SUPER_BIT = 18;

  typedef enum logic [1:0] {PH_IDLE, PH_L1, PH_L2} phase_t;

  typedef enum logic {OP_REQUEST, OP_DESC} op_t;
  typedef enum logic {KIND_READ, KIND_DONE} kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_L1_FAULT, ST_L2_FAULT, ST_RESERVED
  } status_t;

  // first-level descriptor type field
  typedef enum logic [1:0] {
    L1_FAULT, L1_TABLE, L1_SECTION, L1_RESERVED
  } l1_type_t;

  // second-level type codes; both remaining codes are small pages
  localparam logic [1:0] L2_FAULT = 2'd0;
  localparam logic [1:0] L2_LARGE = 2'd1;

  // register indexes
  localparam logic REG_TB0 = 1'b0;
  localparam logic REG_TB1 = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] table_base_zero;
    logic [CFG_W-1:0] table_base_one;
  } cfg_t;

  typedef struct packed {
    op_t              operation;
    logic [VA_W-1:0]  virt_addr;
    logic             base_select;
    logic [DESC_W-1:0] read_data;
  } item_t;

  typedef struct packed {
    kind_t           kind;
    logic [PA_W-1:0] address;
    status_t         status;
  } result_t;

endpackage

>>> hdl/sdtw_apb_regs.sv
// APB register file holding the two table base registers.
// Depends on sdtw_pkg.
module sdtw_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sdtw_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [sdtw_pkg::CFG_W-1:0]  cfg_pwdata,
  output logic [sdtw_pkg::CFG_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output sdtw_pkg::cfg_t              cfg
);
  import sdtw_pkg::*;

  logic [CFG_W-1:0] tb0_r, tb0_nxt;
  logic [CFG_W-1:0] tb1_r, tb1_nxt;
  logic             wr_en;
  logic             reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // word-aligned decode
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    tb0_nxt = tb0_r;
    tb1_nxt = tb1_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TB0: tb0_nxt = cfg_pwdata;
        REG_TB1: tb1_nxt = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb0_r <= '0;
      tb1_r <= '0;
    end else begin
      tb0_r <= tb0_nxt;
      tb1_r <= tb1_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == REG_TB1) ? tb1_r : tb0_r;
  assign cfg.table_base_zero = tb0_r;
  assign cfg.table_base_one  = tb1_r;

endmodule

>>> hdl/sdtw_walk.sv
// Walk engine: input register, walk-phase state, descriptor decode and
// result register. Depends on sdtw_pkg and the assertion macro header.
`include "short_descriptor_table_walk_assert.svh"
module sdtw_walk (
  input  logic              clk,
  input  logic              rst_n,
  input  sdtw_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdtw_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output sdtw_pkg::result_t out_res
);
  import sdtw_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  phase_t           phase_r, phase_nxt;
  logic [VA_W-1:0]  held_va_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;

  logic             out_free;
  logic             s1_move;
  logic             emit;
  logic             start_walk;
  result_t          res;
  logic [CFG_W-1:0] base;
  logic [DESC_W-1:0] d;
  logic [VA_W-1:0]  va;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  assign d  = s1_item_r.read_data;
  assign va = held_va_r;
  assign base = s1_item_r.base_select ? cfg.table_base_one : cfg.table_base_zero;
  assign start_walk = s1_move && (s1_item_r.operation == OP_REQUEST) && (phase_r == PH_IDLE);

  // next walk phase
  always_comb begin
    phase_nxt = phase_r;
    if (s1_move) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (s1_item_r.operation == OP_REQUEST) phase_nxt = PH_L1;
        end
        PH_L1: begin
          if (s1_item_r.operation == OP_DESC) begin
            phase_nxt = (l1_type_t'(d[1:0]) == L1_TABLE) ? PH_L2 : PH_IDLE;
          end
        end
        PH_L2: begin
          if (s1_item_r.operation == OP_DESC) phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result decode
  always_comb begin
    emit = 1'b0;
    res.kind    = KIND_DONE;
    res.address = '0;
    res.status  = ST_OK;
    unique case (phase_r)
      PH_IDLE: begin
        if (s1_item_r.operation == OP_REQUEST) begin
          emit = 1'b1;
          res.kind = KIND_READ;
          res.address = {8'd0, base[31:14], s1_item_r.virt_addr[31:20], 2'b00};
        end
      end
      PH_L1: begin
        if (s1_item_r.operation == OP_DESC) begin
          emit = 1'b1;
          unique case (l1_type_t'(d[1:0]))
            L1_FAULT: res.status = ST_L1_FAULT;
            L1_TABLE: begin
              res.kind = KIND_READ;
              res.address = {8'd0, d[31:10], va[19:12], 2'b00};
            end
            L1_SECTION: begin
              if (d[SUPER_BIT]) begin
                res.address = {d[8:5], d[23:20], d[31:24], va[23:0]};
              end else begin
                res.address = {8'd0, d[31:20], va[19:0]};
              end
            end
            L1_RESERVED: res.status = ST_RESERVED;
            default: ;
          endcase
        end
      end
      PH_L2: begin
        if (s1_item_r.operation == OP_DESC) begin
          emit = 1'b1;
          priority if (d[1:0] == L2_FAULT) begin
            res.status = ST_L2_FAULT;
          end else if (d[1:0] == L2_LARGE) begin
            res.address = {8'd0, d[31:16], va[15:0]};
          end else begin
            res.address = {8'd0, d[31:12], va[11:0]};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (s1_move)         s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_move && emit) out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_item;
    if (start_walk)           held_va_r <= s1_item_r.virt_addr;
    if (s1_move && emit)      out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `SDTW_ASSERT_NEXT(a_req_gives_read, start_walk,
                    out_valid_r && out_res_r.kind == KIND_READ && phase_r == PH_L1,
                    "request in idle did not issue a first-level read")
  `SDTW_ASSERT(a_fault_zero_addr,
               !out_valid_r || out_res_r.status == ST_OK || out_res_r.address == '0,
               "fault result with nonzero address")
  `SDTW_ASSERT(a_read_status_ok,
               !out_valid_r || out_res_r.kind != KIND_READ || out_res_r.status == ST_OK,
               "read request with nonzero status")
  `SDTW_ASSERT_NEXT(a_done_ends_walk, s1_move && emit && res.kind == KIND_DONE,
                    phase_r == PH_IDLE,
                    "walk not idle after a finished translation")

endmodule

>>> hdl/short_descriptor_table_walk.sv
// Short-descriptor two-level table walker. Result path: input register, then
// decode into result register, loaded only by items that emit a result.
// Throughput: one item per cycle while out_tready is high; the walk-phase
// register updates in the same cycle as the decode, so the next item sees it
// at once. A held result stalls a full input register and drops in_tready.
// Reset (rst_n low, synchronous): walk idle, pipeline empty, table bases 0.
module short_descriptor_table_walk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [63:0]                  in_tdata,  // virt_addr[31:0], read_data[63:32]
  input  logic [1:0]                   in_tuser,  // operation[0], base_select[1]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata, // address[39:0], status[41:40], zero
  output logic [0:0]                   out_tuser, // kind[0]
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sdtw_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [sdtw_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [sdtw_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import sdtw_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  result_t out_res;

  assign in_item.operation   = op_t'(in_tuser[0]);
  assign in_item.base_select = in_tuser[1];
  assign in_item.virt_addr   = in_tdata[31:0];
  assign in_item.read_data   = in_tdata[63:32];

  sdtw_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sdtw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'd0, out_res.status, out_res.address};
  assign out_tuser = out_res.kind;

endmodule
